// ===== design/assert_macros.svh =====
// Assertion macros used by the framer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bscf_pkg.sv =====
// Types and constants of the bit-stuffing CRC framer.
package bscf_pkg;

    localparam int CRC_WIDTH_DEF = 3;
    localparam int STUFF_RUN_DEF = 5;

    localparam int FLAG_BITS  = 8;
    localparam int FLAG_IDX_W = 3;
    localparam int GEN_TAPS_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [GEN_TAPS_W-1:0] GEN_TAPS_RST = 3'd3;
    localparam logic [FLAG_BITS-1:0]  FLAG_RST     = 8'h7e;

    localparam logic [CFG_IDX_W-1:0] CFG_GEN_TAPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 2'd1;

    localparam logic [1:0] KIND_FLAG    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STUFF   = 2'd2;
    localparam logic [1:0] KIND_CRC     = 2'd3;

    typedef struct packed {
        logic data_bit;
        logic end_of_frame;
    } t_in_beat;

    typedef struct packed {
        logic       line_bit;
        logic [1:0] bit_kind;
        logic       last_of_run;
    } t_out_beat;

    // What one input beat expands to on the line.
    typedef struct packed {
        logic open_flag;
        logic data_bit;
        logic stuff;
        logic close;
    } t_desc_ctl;

endpackage

// ===== design/bscf_enc.sv =====
// Frame state, bit stuffing decision and CRC update for one input beat.
module bscf_enc #(
    parameter int CRC_WIDTH = bscf_pkg::CRC_WIDTH_DEF,
    parameter int STUFF_RUN = bscf_pkg::STUFF_RUN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  bscf_pkg::t_in_beat   i_beat,
    input  logic [CRC_WIDTH-1:0] i_taps,
    output bscf_pkg::t_desc_ctl  o_ctl,
    output logic [CRC_WIDTH-1:0] o_crc
);

    localparam int ONES_W = $clog2(STUFF_RUN + 1);
    localparam logic [ONES_W-1:0] RUN_END = ONES_W'(STUFF_RUN);

    logic                 r_in_frame;
    logic [ONES_W-1:0]    r_ones;
    logic [CRC_WIDTH-1:0] r_rem;
    logic                 n_in_frame;
    logic [ONES_W-1:0]    n_ones;
    logic [CRC_WIDTH-1:0] n_rem;

    logic [ONES_W-1:0]    ones_cur;
    logic [ONES_W-1:0]    ones_inc;
    logic [CRC_WIDTH-1:0] rem_cur;
    logic [CRC_WIDTH-1:0] rem_pay;
    logic [CRC_WIDTH-1:0] rem_stf;
    logic                 stuff;

    always_comb begin
        // A closed frame restarts from a clean run count and CRC.
        ones_cur = r_in_frame ? r_ones : '0;
        rem_cur  = r_in_frame ? r_rem : '0;

        rem_pay = (rem_cur << 1) ^
                  ((rem_cur[CRC_WIDTH-1] ^ i_beat.data_bit) ? i_taps : '0);
        ones_inc = ones_cur + ONES_W'(1);
        stuff    = i_beat.data_bit && (ones_inc == RUN_END);
        // Feed the stuffed zero into the CRC too.
        rem_stf  = (rem_pay << 1) ^ (rem_pay[CRC_WIDTH-1] ? i_taps : '0);

        o_ctl.open_flag = !r_in_frame;
        o_ctl.data_bit  = i_beat.data_bit;
        o_ctl.stuff     = stuff;
        o_ctl.close     = i_beat.end_of_frame;
        o_crc           = stuff ? rem_stf : rem_pay;

        if (i_beat.end_of_frame) begin
            n_in_frame = 1'b0;
            n_ones     = '0;
            n_rem      = '0;
        end else begin
            n_in_frame = 1'b1;
            n_ones     = (i_beat.data_bit && !stuff) ? ones_inc : '0;
            n_rem      = o_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_ones     <= '0;
            r_rem      <= '0;
        end else if (i_accept) begin
            r_in_frame <= n_in_frame;
            r_ones     <= n_ones;
            r_rem      <= n_rem;
        end
    end

endmodule

// ===== design/bscf_ser.sv =====
// Beat register and line serializer: flag, payload, stuff, CRC, closing flag.
module bscf_ser #(
    parameter int CRC_WIDTH = bscf_pkg::CRC_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bscf_pkg::t_desc_ctl           i_ctl,
    input  logic [CRC_WIDTH-1:0]          i_crc,
    input  logic [bscf_pkg::FLAG_BITS-1:0] i_flag,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bscf_pkg::t_out_beat           o_out
);

    localparam int CNT_W = $clog2((CRC_WIDTH > bscf_pkg::FLAG_BITS) ?
                                  CRC_WIDTH : bscf_pkg::FLAG_BITS);
    localparam logic [CNT_W-1:0] FLAG_LAST = CNT_W'(bscf_pkg::FLAG_BITS - 1);
    localparam logic [CNT_W-1:0] CRC_LAST  = CNT_W'(CRC_WIDTH - 1);

    localparam logic [2:0] PH_OPEN  = 3'd0;
    localparam logic [2:0] PH_PAY   = 3'd1;
    localparam logic [2:0] PH_STUFF = 3'd2;
    localparam logic [2:0] PH_CRC   = 3'd3;
    localparam logic [2:0] PH_CLOSE = 3'd4;

    logic                 r_busy;
    logic [2:0]           r_phase;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_stuff;
    logic                 r_close;
    logic                 r_data;
    logic [CRC_WIDTH-1:0] r_crc;
    logic                 r_out_valid;
    bscf_pkg::t_out_beat  r_out;

    logic [2:0]           n_phase;
    logic [CNT_W-1:0]     n_cnt;
    logic [CRC_WIDTH-1:0] n_crc;

    logic                 out_free;
    logic                 adv;
    logic                 acc;
    logic                 is_last;
    bscf_pkg::t_out_beat  elem;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_busy && out_free;
    assign o_in_stall = r_busy && !(out_free && is_last);
    assign acc        = i_in_valid && !o_in_stall;

    always_comb begin
        elem.line_bit = 1'b0;
        elem.bit_kind = bscf_pkg::KIND_FLAG;
        is_last       = 1'b0;
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_crc         = r_crc;
        case (r_phase)
            PH_OPEN: begin
                elem.line_bit = i_flag[r_cnt[bscf_pkg::FLAG_IDX_W-1:0]];
                elem.bit_kind = bscf_pkg::KIND_FLAG;
                if (r_cnt == '0) begin
                    n_phase = PH_PAY;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            PH_PAY: begin
                elem.line_bit = r_data;
                elem.bit_kind = bscf_pkg::KIND_PAYLOAD;
                if (r_stuff) begin
                    n_phase = PH_STUFF;
                end else if (r_close) begin
                    n_phase = PH_CRC;
                    n_cnt   = CRC_LAST;
                end else begin
                    is_last = 1'b1;
                end
            end
            PH_STUFF: begin
                elem.line_bit = 1'b0;
                elem.bit_kind = bscf_pkg::KIND_STUFF;
                if (r_close) begin
                    n_phase = PH_CRC;
                    n_cnt   = CRC_LAST;
                end else begin
                    is_last = 1'b1;
                end
            end
            PH_CRC: begin
                elem.line_bit = r_crc[CRC_WIDTH-1];
                elem.bit_kind = bscf_pkg::KIND_CRC;
                n_crc         = r_crc << 1;
                if (r_cnt == '0) begin
                    n_phase = PH_CLOSE;
                    n_cnt   = FLAG_LAST;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            PH_CLOSE: begin
                elem.line_bit = i_flag[r_cnt[bscf_pkg::FLAG_IDX_W-1:0]];
                elem.bit_kind = bscf_pkg::KIND_FLAG;
                if (r_cnt == '0) begin
                    is_last = 1'b1;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
        elem.last_of_run = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_PAY;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_busy  <= 1'b1;
                r_phase <= i_ctl.open_flag ? PH_OPEN : PH_PAY;
                r_cnt   <= FLAG_LAST;
            end else if (adv) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_data  <= i_ctl.data_bit;
            r_stuff <= i_ctl.stuff;
            r_close <= i_ctl.close;
            r_crc   <= i_crc;
        end else if (adv) begin
            r_crc <= n_crc;
        end
        if (adv) begin
            r_out <= elem;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== design/bit_stuff_crc_framer_core.sv =====
// Bit-stuffing frame transmitter with a short CRC: top level.
//
// One payload bit enters per beat; the block sends one line bit per cycle
// while the output is not stalled, so plain payload streams at one bit per
// clock. The first bit of a frame adds the 8 opening flag bits, a stuffed
// zero adds one line bit, and the last bit adds CRC_WIDTH CRC bits plus the 8
// closing flag bits. The output serializer drives one line bit per cycle
// unless the output stalls; the input is stalled while it works through the
// extra bits of an item and accepted again in the cycle the last one is
// loaded into the output register.
// Write configuration only while no beat is in flight: the generator taps are
// taken when a beat is accepted and the flag is read as its bits go out.
`include "assert_macros.svh"

module bit_stuff_crc_framer_core #(
    parameter int CRC_WIDTH = bscf_pkg::CRC_WIDTH_DEF,
    parameter int STUFF_RUN = bscf_pkg::STUFF_RUN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bscf_pkg::t_in_beat              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bscf_pkg::t_out_beat             o_out,
    input  logic                            i_cfg_we,
    input  logic [bscf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bscf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TAP_EXT_W = CRC_WIDTH + bscf_pkg::GEN_TAPS_W;

    logic [bscf_pkg::GEN_TAPS_W-1:0] r_gen_taps;
    logic [bscf_pkg::FLAG_BITS-1:0]  r_flag;
    logic [TAP_EXT_W-1:0]            taps_ext;
    logic [CRC_WIDTH-1:0]            taps;
    logic                            in_acc;
    bscf_pkg::t_desc_ctl             ctl;
    logic [CRC_WIDTH-1:0]            crc;
    logic                            out_stf;
    logic                            out_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_taps <= bscf_pkg::GEN_TAPS_RST;
            r_flag     <= bscf_pkg::FLAG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bscf_pkg::CFG_GEN_TAPS: r_gen_taps <= i_cfg_data[bscf_pkg::GEN_TAPS_W-1:0];
                bscf_pkg::CFG_FLAG:     r_flag     <= i_cfg_data[bscf_pkg::FLAG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Zero-extend or trim the taps to the CRC width.
    assign taps_ext = TAP_EXT_W'(r_gen_taps);
    assign taps     = taps_ext[CRC_WIDTH-1:0];
    assign in_acc   = i_in_valid && !o_in_stall;

    bscf_enc #(
        .CRC_WIDTH (CRC_WIDTH),
        .STUFF_RUN (STUFF_RUN)
    ) u_enc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_beat   (i_in),
        .i_taps   (taps),
        .o_ctl    (ctl),
        .o_crc    (crc)
    );

    bscf_ser #(
        .CRC_WIDTH (CRC_WIDTH)
    ) u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_ctl       (ctl),
        .i_crc       (crc),
        .i_flag      (r_flag),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    assign out_stf = o_out_valid && (o_out.bit_kind == bscf_pkg::KIND_STUFF);
    assign out_crc = o_out_valid && (o_out.bit_kind == bscf_pkg::KIND_CRC);

    `ASSERT_ON(a_stuff_is_zero, i_clk, i_rst_n, out_stf |-> !o_out.line_bit, "stuffed bit not zero")
    `ASSERT_ON(a_crc_not_last, i_clk, i_rst_n, out_crc |-> !o_out.last_of_run, "crc bit marked last")
    `ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
